/* sv/byte_pattern_delete_replace_macros.svh */
// ----------------------------------------------------------------------------
// byte_pattern_delete_replace_macros
// Assertion helpers shared by the find/replace RTL. Both expect clk_i and
// rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef BYTE_PATTERN_DELETE_REPLACE_MACROS_SVH
`define BYTE_PATTERN_DELETE_REPLACE_MACROS_SVH

// same-cycle implication
`define BPDR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bpdr assertion failed");

// next-cycle implication
`define BPDR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bpdr assertion failed");

`endif

/* sv/bpdr_pkg.sv */
// ----------------------------------------------------------------------------
// bpdr_pkg
// Types, register indexes and helpers for the byte find/replace block.
// ----------------------------------------------------------------------------
package bpdr_pkg;

  localparam int RegBytes      = 8;
  localparam int ByteIdxW      = $clog2(RegBytes);
  localparam int MaxPatternDef = 8;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 64;

  localparam logic [CfgIdxW-1:0] RegMode     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPatLen   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPatBytes = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRepLen   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRepBytes = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } bpdr_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       end_of_run;
    logic       end_of_stream_out;
  } bpdr_out_t;

  // one input's worth of output bytes, oldest in entry 0
  typedef struct packed {
    logic [RegBytes-1:0][7:0] bytes;
    logic [3:0]               count;
    logic                     present;
    logic                     eos;
  } bpdr_burst_t;

  function automatic logic [3:0] clamp_len(logic [3:0] v, logic [3:0] top);
    logic [3:0] r;
    if (v == 4'd0) begin
      r = 4'd1;
    end else if (v > top) begin
      r = top;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* sv/bpdr_cell.sv */
// ----------------------------------------------------------------------------
// bpdr_cell
// One window cell: holds the byte of its age, compares the byte arriving
// from its neighbor against the pattern byte that lines up with it.
// ----------------------------------------------------------------------------
module bpdr_cell
  import bpdr_pkg::*;
#(
  parameter int Idx = 0
) (
  input  logic                clk_i,
  input  logic                shift_i,
  input  logic [7:0]          byte_i,
  input  logic [3:0]          pat_len_i,
  input  logic [CfgDataW-1:0] pattern_i,
  output logic [7:0]          byte_o,
  output logic                match_o
);

  logic [RegBytes-1:0][7:0] pat;
  logic [3:0]               sel;
  logic [7:0]               byte_q;

  assign pat = pattern_i;
  assign sel = pat_len_i - 4'(Idx) - 4'd1;

  assign match_o = (4'(Idx) >= pat_len_i) || (byte_i == pat[sel[ByteIdxW-1:0]]);
  assign byte_o  = byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

endmodule

/* sv/bpdr_emit.sv */
// ----------------------------------------------------------------------------
// bpdr_emit
// Output burst buffer: takes up to eight bytes per input and hands them out
// one per transaction, flagging the last of the run and of the stream.
// ----------------------------------------------------------------------------
`include "byte_pattern_delete_replace_macros.svh"

module bpdr_emit
  import bpdr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  bpdr_burst_t burst_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output bpdr_out_t   out_data_o,
  output logic        can_load_o
);

  logic [RegBytes-1:0][7:0] bytes_q, bytes_d;
  logic [3:0]               cnt_q, cnt_d;
  logic                     present_q, present_d;
  logic                     eos_q, eos_d;
  logic                     take;

  assign out_valid_o = (cnt_q != 4'd0);
  assign take        = out_valid_o && out_ready_i;
  assign can_load_o  = (cnt_q == 4'd0) || ((cnt_q == 4'd1) && out_ready_i);

  assign out_data_o.out_byte          = bytes_q[0];
  assign out_data_o.byte_present      = present_q;
  assign out_data_o.end_of_run        = (cnt_q == 4'd1);
  assign out_data_o.end_of_stream_out = (cnt_q == 4'd1) && eos_q;

  always_comb begin
    bytes_d   = bytes_q;
    cnt_d     = cnt_q;
    present_d = present_q;
    eos_d     = eos_q;
    if (load_i) begin
      bytes_d   = burst_i.bytes;
      cnt_d     = burst_i.count;
      present_d = burst_i.present;
      eos_d     = burst_i.eos;
    end else if (take) begin
      for (int k = 0; k < RegBytes - 1; k++) begin
        bytes_d[k] = bytes_q[k+1];
      end
      bytes_d[RegBytes-1] = 8'h00;
      cnt_d = cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= 4'd0;
      present_q <= 1'b0;
      eos_q     <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      present_q <= present_d;
      eos_q     <= eos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  `BPDR_ASSERT_IMP(a_load_slot, load_i, (cnt_q == 4'd0) || ((cnt_q == 4'd1) && out_ready_i))
  `BPDR_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= 4'(RegBytes))
  `BPDR_ASSERT_NXT(a_run_holds, cnt_q > 4'd1, cnt_q != 4'd0)
  `BPDR_ASSERT_IMP(a_marker_single, (cnt_q != 4'd0) && !present_q, cnt_q == 4'd1)

endmodule

/* sv/byte_pattern_delete_replace.sv */
// ----------------------------------------------------------------------------
// byte_pattern_delete_replace
// Streaming find/replace: a chain of window cells matches a pattern of up to
// eight bytes; matches are deleted or replaced, other bytes pass in order.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------
//   input    | in_valid_i / in_ready_o  | in_data_i
//   output   | out_valid_o / out_ready_i| out_data_o
//   config   | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// While the output is ready, an input producing one result is taken every
// cycle; a burst of n results (replacement or end-of-stream flush, n <= 8)
// holds input until the single-entry output burst buffer, draining one byte
// per cycle while the output is ready, hands out its last one. Results appear
// in the cycle after acceptance; a stalled output holds its byte. No clearing pass after reset.
// ----------------------------------------------------------------------------
module byte_pattern_delete_replace
  import bpdr_pkg::*;
#(
  parameter int MAX_PATTERN = MaxPatternDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bpdr_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bpdr_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int WinDepth = (MAX_PATTERN < RegBytes) ? MAX_PATTERN : RegBytes;
  localparam int CntW     = $clog2(WinDepth + 1);

  logic                     mode_q;
  logic [3:0]               pat_len_q;
  logic [CfgDataW-1:0]      pat_bytes_q;
  logic [3:0]               rep_len_q;
  logic [RegBytes-1:0][7:0] rep_bytes_q;
  logic [CntW-1:0]          win_cnt_q, win_cnt_d;

  logic [3:0]        len, rlen, cnt4, c, total;
  logic [7:0]        age [WinDepth];
  logic [7:0]        cell_q [WinDepth];
  logic [WinDepth-1:0] match;
  logic              accept, eos, full, hit, load;
  logic [3:0]        flush_cnt;
  bpdr_burst_t       burst;

  assign accept = in_valid_i && in_ready_o;
  assign eos    = in_data_i.end_of_stream;
  assign len    = clamp_len(pat_len_q, 4'(WinDepth));
  assign rlen   = clamp_len(rep_len_q, 4'(RegBytes));
  assign total  = (rlen > len) ? rlen : len;
  assign cnt4   = 4'(win_cnt_q);
  assign c      = ((cnt4 >= len) ? 4'd0 : cnt4) + 4'd1;
  assign full   = (c == len);
  assign hit    = full && (&match);

  assign age[0] = in_data_i.data_byte;

  for (genvar j = 0; j < WinDepth; j++) begin : g_cell
    if (j > 0) begin : g_link
      assign age[j] = cell_q[j-1];
    end
    bpdr_cell #(
      .Idx (j)
    ) u_cell (
      .clk_i     (clk_i),
      .shift_i   (accept),
      .byte_i    (age[j]),
      .pat_len_i (len),
      .pattern_i (pat_bytes_q),
      .byte_o    (cell_q[j]),
      .match_o   (match[j])
    );
  end

  assign flush_cnt = eos ? c : (full ? 4'd1 : 4'd0);

  always_comb begin
    burst         = '0;
    burst.present = 1'b1;
    burst.eos     = eos;
    if (hit) begin
      if (mode_q) begin
        burst.count = total;
        for (int k = 0; k < RegBytes; k++) begin
          if (4'(k) < rlen) begin
            burst.bytes[k] = rep_bytes_q[k];
          end
        end
      end
    end else begin
      burst.count = flush_cnt;
      for (int k = 0; k < RegBytes; k++) begin
        for (int j = 0; j < WinDepth; j++) begin
          if (int'(c) == j + k + 1) begin
            burst.bytes[k] = age[j];
          end
        end
      end
    end
    if (eos && (burst.count == 4'd0)) begin
      burst.count   = 4'd1;
      burst.present = 1'b0;
      burst.bytes   = '0;
    end
  end

  assign load = accept && (burst.count != 4'd0);

  always_comb begin
    win_cnt_d = win_cnt_q;
    if (cfg_we_i && (cfg_index_i == RegPatLen)) begin
      win_cnt_d = '0;
    end else if (accept) begin
      if (hit || eos) begin
        win_cnt_d = '0;
      end else if (full) begin
        win_cnt_d = CntW'(c - 4'd1);
      end else begin
        win_cnt_d = CntW'(c);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      pat_len_q   <= 4'd1;
      pat_bytes_q <= '0;
      rep_len_q   <= 4'd1;
      rep_bytes_q <= '0;
      win_cnt_q   <= '0;
    end else begin
      win_cnt_q <= win_cnt_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegMode:     mode_q      <= cfg_data_i[0];
          RegPatLen:   pat_len_q   <= cfg_data_i[3:0];
          RegPatBytes: pat_bytes_q <= cfg_data_i;
          RegRepLen:   rep_len_q   <= cfg_data_i[3:0];
          RegRepBytes: rep_bytes_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  bpdr_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .burst_i     (burst),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .can_load_o  (in_ready_o)
  );

endmodule
